// File: design/rfh_pkg.sv
// shared types, constants and helpers for the ring feedback hash
package rfh_pkg;

  localparam int unsigned WORD_W     = 64;
  localparam int unsigned CHUNK_W    = 4 * WORD_W;
  localparam int unsigned CNT_W      = 6;
  localparam int unsigned IN_DATA_W  = 328;
  localparam int unsigned OUT_DATA_W = 256;

  localparam logic [CNT_W-1:0] CHUNK_BYTES = 6'd32;
  localparam logic [7:0]       STOP_BYTE   = 8'h80;
  localparam logic [63:0]      C_MIX1      = 64'hff51afd7ed558ccd;
  localparam logic [63:0]      C_MIX2      = 64'hc4ceb9fe1a85ec53;

  typedef enum logic [1:0] {
    KIND_FULL = 2'd0,
    KIND_TAIL = 2'd1,
    KIND_NONE = 2'd2
  } kind_t;

  typedef struct packed {
    logic [3:0][63:0] words;
    logic [63:0]      len;
    logic             first;
    logic             fin;
    kind_t            kind;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic busy;
  } bk_stat_t;

  function automatic logic [63:0] ring_k(input logic [2:0] idx);
    logic [63:0] k;
    case (idx)
      3'd0:    k = 64'h9e3779b185ebca87;
      3'd1:    k = 64'hbb67ae8584caa73b;
      3'd2:    k = 64'h3c6ef372fe94f82b;
      3'd3:    k = 64'ha54ff53a5f1d36f1;
      3'd4:    k = 64'h510e527fade682d1;
      3'd5:    k = 64'h9b05688c2b03e58a;
      3'd6:    k = 64'h1f12759bd39c024f;
      3'd7:    k = 64'h5be0cd19137e2179;
      default: k = 64'h0;
    endcase
    return k;
  endfunction

  function automatic logic [63:0] rotl(input logic [63:0] v, input int unsigned amt);
    logic [63:0] r;
    r = (v << amt) | (v >> (64 - amt));
    return r;
  endfunction

endpackage

// File: design/rfh_front.sv
// input stage: saturates the byte count, pads tails and classifies each chunk
module rfh_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // block_word0, block_word1, block_word2, block_word3, bytes_valid, msg_length
  input  logic [rfh_pkg::IN_DATA_W-1:0]   in_tdata,
  // first
  input  logic                            in_tuser,
  input  logic                            in_tlast,
  input  rfh_pkg::q_stat_t                q_stat,
  output logic                            push_en,
  output rfh_pkg::item_t                  push_item
);
  import rfh_pkg::*;

  logic [CNT_W-1:0]   n_raw;
  logic [CNT_W-1:0]   n_sat;
  logic [CHUNK_W-1:0] padded;
  item_t              item;
  logic               f_v_r;
  logic               f_v_nxt;
  item_t              f_item_r;
  item_t              f_item_nxt;
  logic               accept;

  assign n_raw = in_tdata[261:256];
  assign n_sat = (n_raw > CHUNK_BYTES) ? CHUNK_BYTES : n_raw;

  always_comb begin
    for (int b = 0; b < 32; b++) begin
      if (6'(b) < n_sat) begin
        padded[b*8 +: 8] = in_tdata[b*8 +: 8];
      end else if ((6'(b) == n_sat) && (n_sat != '0)) begin
        padded[b*8 +: 8] = STOP_BYTE;
      end else begin
        padded[b*8 +: 8] = 8'h00;
      end
    end
  end

  always_comb begin
    item.words = padded;
    item.len   = in_tdata[325:262];
    item.first = in_tuser;
    item.fin   = in_tlast || (n_sat != CHUNK_BYTES);
    if (n_sat == CHUNK_BYTES) begin
      item.kind = KIND_FULL;
    end else if (n_sat == '0) begin
      item.kind = KIND_NONE;
    end else begin
      item.kind = KIND_TAIL;
    end
  end

  assign push_en   = f_v_r && !q_stat.full;
  assign push_item = f_item_r;
  assign in_tready = !f_v_r || !q_stat.full;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    f_v_nxt    = f_v_r;
    f_item_nxt = f_item_r;
    if (accept) begin
      f_v_nxt    = 1'b1;
      f_item_nxt = item;
    end else if (push_en) begin
      f_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else begin
      f_v_r <= f_v_nxt;
    end
    f_item_r <= f_item_nxt;
  end

endmodule

// File: design/rfh_fifo.sv
// short queue of classified chunks between front and core
module rfh_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_en,
  input  rfh_pkg::item_t   push_item,
  input  logic             pop_en,
  output rfh_pkg::item_t   head,
  output rfh_pkg::q_stat_t q_stat
);
  import rfh_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  item_t         mem [DEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r;
  logic [AW-1:0] rd_ptr_nxt;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;

  assign head         = mem[rd_ptr_r];
  assign q_stat.full  = (count_r == CW'(DEPTH));
  assign q_stat.empty = (count_r == '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_en) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_en) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_en && !pop_en) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_en && !push_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

endmodule

// File: design/rfh_core.sv
// mixing core: state words, shared 32x32 multiplier, finish and digest register
module rfh_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [63:0]                      seed,
  input  rfh_pkg::item_t                   head,
  input  rfh_pkg::q_stat_t                 q_stat,
  output logic                             pop_en,
  output rfh_pkg::bk_stat_t                bk_stat,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // digest0, digest1, digest2, digest3
  output logic [rfh_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import rfh_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_PREP = 4'b0010,
    ST_MUL  = 4'b0100,
    ST_WB   = 4'b1000
  } state_t;

  typedef enum logic [1:0] {
    MODE_FULL = 2'd0,
    MODE_TAIL = 2'd1,
    MODE_FIN1 = 2'd2,
    MODE_FIN2 = 2'd3
  } mode_t;

  localparam logic [1:0] CNT_LAST = 2'd3;

  state_t           st_r, st_nxt;
  mode_t            mode_r, mode_nxt;
  logic [7:0][63:0] s_r, s_nxt;
  item_t            it_r, it_nxt;
  logic [3:0][63:0] op_r, op_nxt;
  logic [63:0]      prod_r, prod_nxt;
  logic [1:0]       ph_r, ph_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             out_v_r, out_v_nxt;
  logic [3:0][63:0] out_d_r, out_d_nxt;

  logic [7:0][63:0] s_init;
  logic [7:0][63:0] p;
  logic [7:0][63:0] full_s;
  logic [3:0][63:0] full_op;
  logic [7:0][63:0] fin_s;
  logic [3:0][63:0] fin_op;
  logic [3:0][63:0] x;
  logic [3:0][63:0] m;
  logic [63:0]      k_sel;
  logic [31:0]      mul_a;
  logic [31:0]      mul_b;
  logic [63:0]      mul_p;
  logic [63:0]      prod_sum;
  logic             out_free;

  assign pop_en       = (st_r == ST_IDLE) && !q_stat.empty;
  assign bk_stat.busy = (st_r != ST_IDLE);
  assign out_tvalid   = out_v_r;
  assign out_tdata    = out_d_r;
  assign out_free     = !out_v_r || out_tready;

  // state load for a first chunk
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      s_init[i]     = seed ^ ring_k(3'(i));
      s_init[i + 4] = head.len ^ ring_k(3'(i + 4));
    end
  end

  // full chunk absorb, ring feedback operands
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      p[j]     = s_r[j] ^ it_r.words[j];
      p[j + 4] = s_r[j + 4] + p[j];
    end
    full_s      = s_r;
    full_s[4]   = rotl(p[4] + p[3], 37) ^ ring_k(3'd4);
    full_s[5]   = rotl(p[5] + p[4], 41) ^ ring_k(3'd5);
    full_s[6]   = rotl(p[6] + p[5], 17) ^ ring_k(3'd6);
    full_s[7]   = rotl(p[7] + p[6], 29) ^ ring_k(3'd7);
    full_op[0]  = rotl(p[0] ^ p[7], 23);
    full_op[1]  = rotl(p[1] ^ p[0], 19);
    full_op[2]  = rotl(p[2] ^ p[1], 31);
    full_op[3]  = rotl(p[3] ^ p[2], 13);
  end

  // butterfly finish
  always_comb begin
    fin_s = s_r;
    for (int i = 0; i < 4; i++) begin
      fin_s[i] = fin_s[i] ^ rotl(fin_s[i + 4], 27);
    end
    fin_s[0] = fin_s[0] ^ rotl(fin_s[2], 13);
    fin_s[1] = fin_s[1] ^ rotl(fin_s[3], 13);
    fin_s[4] = fin_s[4] ^ rotl(fin_s[6], 13);
    fin_s[5] = fin_s[5] ^ rotl(fin_s[7], 13);
    for (int i = 0; i < 8; i += 2) begin
      fin_s[i] = fin_s[i] + fin_s[i + 1];
    end
    for (int i = 0; i < 4; i++) begin
      x[i]      = fin_s[i] ^ fin_s[i + 4];
      fin_op[i] = x[i] ^ (x[i] >> 33);
    end
  end

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      m[j] = rotl(op_r[j], 15);
    end
  end

  // shared multiplier, low 64 bits of a 64x64 product in three passes
  always_comb begin
    case (mode_r)
      MODE_FIN1: k_sel = C_MIX1;
      MODE_FIN2: k_sel = C_MIX2;
      default:   k_sel = ring_k({1'b0, cnt_r});
    endcase
    case (ph_r)
      2'd0: begin
        mul_a = op_r[0][31:0];
        mul_b = k_sel[31:0];
      end
      2'd1: begin
        mul_a = op_r[0][63:32];
        mul_b = k_sel[31:0];
      end
      default: begin
        mul_a = op_r[0][31:0];
        mul_b = k_sel[63:32];
      end
    endcase
    mul_p    = 64'(mul_a) * 64'(mul_b);
    prod_sum = prod_r + {mul_p[31:0], 32'h0};
  end

  always_comb begin
    st_nxt    = st_r;
    mode_nxt  = mode_r;
    s_nxt     = s_r;
    it_nxt    = it_r;
    op_nxt    = op_r;
    prod_nxt  = prod_r;
    ph_nxt    = ph_r;
    cnt_nxt   = cnt_r;
    out_v_nxt = out_v_r && !out_tready;
    out_d_nxt = out_d_r;
    case (st_r)
      ST_IDLE: begin
        if (pop_en) begin
          it_nxt = head;
          st_nxt = ST_PREP;
          if (head.first) begin
            s_nxt = s_init;
          end
          case (head.kind)
            KIND_FULL: mode_nxt = MODE_FULL;
            KIND_TAIL: mode_nxt = MODE_TAIL;
            default:   mode_nxt = MODE_FIN1;
          endcase
        end
      end
      ST_PREP: begin
        ph_nxt  = '0;
        cnt_nxt = '0;
        st_nxt  = ST_MUL;
        case (mode_r)
          MODE_FULL: begin
            s_nxt  = full_s;
            op_nxt = full_op;
          end
          MODE_TAIL: begin
            op_nxt = it_r.words;
          end
          default: begin
            s_nxt  = fin_s;
            op_nxt = fin_op;
          end
        endcase
      end
      ST_MUL: begin
        case (ph_r)
          2'd0: begin
            prod_nxt = mul_p;
            ph_nxt   = ph_r + 1'b1;
          end
          2'd1: begin
            prod_nxt = prod_sum;
            ph_nxt   = ph_r + 1'b1;
          end
          default: begin
            op_nxt  = {prod_sum, op_r[3:1]};
            ph_nxt  = '0;
            cnt_nxt = cnt_r + 1'b1;
            if (cnt_r == CNT_LAST) begin
              st_nxt = ST_WB;
            end
          end
        endcase
      end
      ST_WB: begin
        case (mode_r)
          MODE_FULL: begin
            for (int j = 0; j < 4; j++) begin
              s_nxt[j] = op_r[j];
            end
            if (it_r.fin) begin
              mode_nxt = MODE_FIN1;
              st_nxt   = ST_PREP;
            end else begin
              st_nxt = ST_IDLE;
            end
          end
          MODE_TAIL: begin
            for (int j = 0; j < 4; j++) begin
              s_nxt[j]     = s_r[j] ^ m[j];
              s_nxt[j + 4] = s_r[j + 4] + m[j];
            end
            mode_nxt = MODE_FIN1;
            st_nxt   = ST_PREP;
          end
          MODE_FIN1: begin
            for (int j = 0; j < 4; j++) begin
              op_nxt[j] = op_r[j] ^ (op_r[j] >> 33);
            end
            mode_nxt = MODE_FIN2;
            ph_nxt   = '0;
            cnt_nxt  = '0;
            st_nxt   = ST_MUL;
          end
          default: begin
            if (out_free) begin
              for (int j = 0; j < 4; j++) begin
                out_d_nxt[j] = op_r[j] ^ (op_r[j] >> 33);
              end
              out_v_nxt = 1'b1;
              st_nxt    = ST_IDLE;
            end
          end
        endcase
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      mode_r  <= MODE_FULL;
      s_r     <= '0;
      ph_r    <= '0;
      cnt_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      mode_r  <= mode_nxt;
      s_r     <= s_nxt;
      ph_r    <= ph_nxt;
      cnt_r   <= cnt_nxt;
      out_v_r <= out_v_nxt;
    end
    it_r    <= it_nxt;
    op_r    <= op_nxt;
    prod_r  <= prod_nxt;
    out_d_r <= out_d_nxt;
  end

endmodule

// File: design/ring_feedback_hash_256.sv
// out_tvalid follows a tail or last chunk after absorb and finish, an empty tail after finish
//   alone, and never a full chunk without last
// one chunk at a time in the core, each product taking three passes through the 32x32 multiplier
// a front register and a 2-entry queue take new chunks while the core and output stall
// reset: synchronous active-low rst_n clears seed and the eight state words to zero,
//   empties the queue and the output register
module ring_feedback_hash_256 #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [63:0]                     cfg_wr_data,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // block_word0, block_word1, block_word2, block_word3, bytes_valid, msg_length
  input  logic [rfh_pkg::IN_DATA_W-1:0]   in_tdata,
  // first
  input  logic                            in_tuser,
  input  logic                            in_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // digest0, digest1, digest2, digest3
  output logic [rfh_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import rfh_pkg::*;

  logic [63:0] seed_r;
  logic [63:0] seed_nxt;
  logic        push_en;
  item_t       push_item;
  logic        pop_en;
  item_t       head;
  q_stat_t     q_stat;
  bk_stat_t    bk_stat;

  assign seed_nxt = cfg_wr_en ? cfg_wr_data : seed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else begin
      seed_r <= seed_nxt;
    end
  end

  rfh_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_stat    (q_stat),
    .push_en   (push_en),
    .push_item (push_item)
  );

  rfh_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_en   (push_en),
    .push_item (push_item),
    .pop_en    (pop_en),
    .head      (head),
    .q_stat    (q_stat)
  );

  rfh_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .seed       (seed_r),
    .head       (head),
    .q_stat     (q_stat),
    .pop_en     (pop_en),
    .bk_stat    (bk_stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  a_queue_flags: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue full and empty at once");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop_en |-> !q_stat.empty)
    else $error("core popped an empty queue");

  a_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    pop_en |=> bk_stat.busy)
    else $error("core idle after taking a chunk");

endmodule
